/* sv/rchs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the radio channel hop selector.
// No dependencies; used by rchs_ctrl, rchs_datapath and the top level.
package rchs_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int NUM_PEERS    = 10;

  localparam int RADIO_W = 2;
  localparam int CH_W    = 4;
  localparam int CNT_W   = 4;
  localparam int SEL_W   = 3;

  localparam logic [SEL_W-1:0] SEL_NONE = 3'b111;

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_FRAME = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // result kinds
  localparam logic KIND_RETUNE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_FREE_TIME     = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;

  localparam logic [CNT_W-1:0] FREE_TIME_RESET     = 4'd5;
  localparam logic [4:0]       CHANNEL_COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_START_EMIT,
    S_HOP_CHECK,
    S_SKIP,
    S_HOP_EMIT,
    S_COUNT,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic capture;
    logic start_init;
    logic frame_apply;
    logic elect;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic hop_load;
    logic skip_step;
    logic hop_commit;
    logic count_up;
    logic emit;
    logic emit_kind;
    logic emit_last;
    logic emit_cur;
  } rchs_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       out_free;
    logic       hop_cur;
    logic       i_last;
    logic       j_last;
  } rchs_status_t;

endpackage

/* sv/radio_channel_hop_selector_top.sv */
`timescale 1ns / 1ps
// Top level of the radio channel hop selector: controller plus datapath.
// Depends on rchs_pkg, rchs_ctrl and rchs_datapath.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata radio,peer; tuser action,sync
//  m_*      | out | m_tvalid/m_tready  | tdata radio,chan,main,backup; tuser kind
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time. A frame produces no result; a start emits one retune
// per radio; a tick emits one retune per hopping radio, then a status beat.
// The collision skip walks the other radios one per cycle through one read
// port of the channel registers. A stalled m_tready holds the sequencer at
// its next result. Reset is synchronous; config writes are always taken.
module radio_channel_hop_selector_top import rchs_pkg::*; #(
  parameter int NUM_RADIOS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] radio_index, [5:2] peer_id, [7:6] zero
  input  logic [2:0]  s_tuser,   // [1:0] action, [2] is_sync_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] tuned_radio, [5:2] channel_index,
                                 // [8:6] main_radio, [11:9] backup_radio, [15:12] zero
  output logic [0:0]  m_tuser,   // [0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  rchs_cmd_t    cmd;
  rchs_status_t status;

  assign cfg_ready = 1'b1;

  rchs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rchs_datapath #(
    .NUM_RADIOS (NUM_RADIOS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // only one item in flight: an accepted beat drops ready for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous item still in work");

  // a status beat always closes its item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == KIND_STATUS) |-> m_tlast)
    else $error("status beat without last");

  // main and backup never name the same radio
  a_main_ne_backup: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:6] != m_tdata[11:9] || m_tdata[8:6] == SEL_NONE))
    else $error("main and backup radio are equal");

  // a chosen main always comes with a backup
  a_backup_with_main: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8:6] != SEL_NONE) |-> (m_tdata[11:9] != SEL_NONE))
    else $error("main radio set without backup");
`endif

endmodule

/* sv/rchs_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine for the hop selector.
// Depends on rchs_pkg; drives rchs_datapath through rchs_cmd_t.
module rchs_ctrl import rchs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rchs_status_t status,
  output rchs_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.action)
          ACT_START: begin
            cmd.start_init = 1'b1;
            cmd.i_clr      = 1'b1;
            state_next     = S_START_EMIT;
          end
          ACT_TICK: begin
            cmd.elect  = 1'b1;
            cmd.i_clr  = 1'b1;
            state_next = S_HOP_CHECK;
          end
          ACT_FRAME: begin
            cmd.frame_apply = 1'b1;
            state_next      = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_START_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_RETUNE;
          cmd.emit_last = status.i_last;
          if (status.i_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.i_inc = 1'b1;
          end
        end
      end
      S_HOP_CHECK: begin
        if (status.hop_cur) begin
          cmd.hop_load = 1'b1;
          cmd.j_clr    = 1'b1;
          state_next   = S_SKIP;
        end else if (status.i_last) begin
          state_next = S_COUNT;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_SKIP: begin
        cmd.skip_step = 1'b1;
        cmd.j_inc     = 1'b1;
        if (status.j_last) begin
          state_next = S_HOP_EMIT;
        end
      end
      S_HOP_EMIT: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_RETUNE;
          cmd.emit_cur   = 1'b1;
          cmd.hop_commit = 1'b1;
          if (status.i_last) begin
            state_next = S_COUNT;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_HOP_CHECK;
          end
        end
      end
      S_COUNT: begin
        cmd.count_up = 1'b1;
        state_next   = S_STATUS;
      end
      S_STATUS: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_STATUS;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/rchs_datapath.sv */
`timescale 1ns / 1ps
// Radio state, config registers, election/hop logic and output register.
// Depends on rchs_pkg; controlled by rchs_ctrl.
module rchs_datapath import rchs_pkg::*; #(
  parameter int NUM_RADIOS = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         cfg_valid,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_data,
  input  rchs_cmd_t    cmd,
  output rchs_status_t status,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,
  output logic [0:0]   m_tuser,
  output logic         m_tlast
);

  localparam int IW = $clog2(NUM_RADIOS);

  // captured item
  logic [1:0]       act_q;
  logic [RADIO_W-1:0] radio_q;
  logic             sync_q;
  logic [3:0]       peer_q;

  logic [CNT_W-1:0] free_time;
  logic [4:0]       channel_count;

  logic [CH_W-1:0]  ch [NUM_RADIOS];
  logic [CNT_W-1:0] fc [NUM_RADIOS];
  logic [SEL_W-1:0] main_sel;
  logic [SEL_W-1:0] backup_sel;
  logic [NUM_RADIOS-1:0] hop;
  logic [IW-1:0]    ri;
  logic [IW-1:0]    rj;
  logic [CH_W-1:0]  cur_ch;

  logic             out_valid;
  logic             out_kind;
  logic [RADIO_W-1:0] out_radio;
  logic [CH_W-1:0]  out_ch;
  logic [SEL_W-1:0] out_main;
  logic [SEL_W-1:0] out_backup;
  logic             out_last;

  logic [4:0]       eff;
  logic [4:0]       quot;
  logic [7:0]       prod;
  logic [CH_W-1:0]  spread_ch [NUM_RADIOS];
  logic             found;
  logic [IW-1:0]    win;
  logic [IW-1:0]    bk;
  logic             do_elect;
  logic [SEL_W-1:0] new_main;
  logic [SEL_W-1:0] new_backup;
  logic [NUM_RADIOS-1:0] elect_hop;
  logic [IW-1:0]    rd_sel;
  logic [CH_W-1:0]  rd_ch;
  logic             frame_clear;

  function automatic logic [CH_W-1:0] advance(input logic [CH_W-1:0] c,
                                              input logic [4:0] n);
    logic [4:0] nx;
    nx = {1'b0, c} + 5'd1;
    return (nx >= n) ? '0 : nx[CH_W-1:0];
  endfunction

  always_comb begin
    eff = (channel_count > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : channel_count;
    // eff / NUM_RADIOS as a compare ladder over the few possible quotients
    quot = '0;
    for (int k = 1; k <= MAX_CHANNELS; k++) begin
      if (k * NUM_RADIOS <= int'(eff)) quot = 5'(k);
    end
    prod = '0;
    for (int k = 0; k < NUM_RADIOS; k++) begin
      prod         = {3'b000, quot} * 8'(NUM_RADIOS - 1 - k);
      spread_ch[k] = prod[CH_W-1:0];
    end

    found = 1'b0;
    win   = '0;
    for (int k = 0; k < NUM_RADIOS; k++) begin
      if (!found && fc[k] == free_time) begin
        found = 1'b1;
        win   = IW'(k);
      end
    end
    // backup ends up as the highest-numbered radio other than main
    bk         = (win == IW'(NUM_RADIOS - 1)) ? IW'(NUM_RADIOS - 2) : IW'(NUM_RADIOS - 1);
    do_elect   = (main_sel == SEL_NONE) && found;
    new_main   = do_elect ? SEL_W'(win) : main_sel;
    new_backup = do_elect ? SEL_W'(bk) : backup_sel;
    for (int k = 0; k < NUM_RADIOS; k++) begin
      elect_hop[k] = (do_elect && IW'(k) != win) ||
                     (fc[k] == '0 && new_main != SEL_W'(k) && new_backup != SEL_W'(k));
    end

    rd_sel = cmd.skip_step ? rj : ri;
    rd_ch  = ch[rd_sel];

    frame_clear = (int'(radio_q) < NUM_RADIOS) && !(sync_q && int'(peer_q) < NUM_PEERS);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q   <= s_tuser[1:0];
      sync_q  <= s_tuser[2];
      radio_q <= s_tdata[1:0];
      peer_q  <= s_tdata[5:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_time     <= FREE_TIME_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
      for (int k = 0; k < NUM_RADIOS; k++) begin
        ch[k] <= '0;
        fc[k] <= CNT_W'(1);
      end
      main_sel   <= SEL_NONE;
      backup_sel <= SEL_NONE;
      hop        <= '0;
      ri         <= '0;
      rj         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FREE_TIME:     free_time     <= cfg_data[CNT_W-1:0];
          CFG_CHANNEL_COUNT: channel_count <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.start_init) begin
        for (int k = 0; k < NUM_RADIOS; k++) begin
          ch[k] <= spread_ch[k];
          fc[k] <= CNT_W'(1);
        end
        main_sel   <= SEL_NONE;
        backup_sel <= SEL_NONE;
      end

      if (cmd.frame_apply && frame_clear) begin
        fc[radio_q[IW-1:0]] <= '0;
      end

      if (cmd.elect) begin
        main_sel   <= new_main;
        backup_sel <= new_backup;
        hop        <= elect_hop;
        for (int k = 0; k < NUM_RADIOS; k++) begin
          if (do_elect && IW'(k) != win) ch[k] <= spread_ch[k];
        end
      end

      if (cmd.i_clr) ri <= '0;
      else if (cmd.i_inc) ri <= ri + IW'(1);
      if (cmd.j_clr) rj <= '0;
      else if (cmd.j_inc) rj <= rj + IW'(1);

      if (cmd.hop_commit) ch[ri] <= cur_ch;

      if (cmd.count_up) begin
        for (int k = 0; k < NUM_RADIOS; k++) begin
          if (fc[k] < free_time) fc[k] <= fc[k] + CNT_W'(1);
        end
      end

      if (cmd.emit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // working channel of the hopping radio; skips past others in index order
  always_ff @(posedge clk) begin
    if (cmd.hop_load) begin
      cur_ch <= advance(rd_ch, eff);
    end else if (cmd.skip_step && rj != ri && cur_ch == rd_ch) begin
      cur_ch <= advance(cur_ch, eff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind   <= cmd.emit_kind;
      out_last   <= cmd.emit_last;
      out_main   <= main_sel;
      out_backup <= backup_sel;
      if (cmd.emit_kind == KIND_STATUS) begin
        out_radio <= '0;
        out_ch    <= '0;
      end else begin
        out_radio <= RADIO_W'(ri);
        out_ch    <= cmd.emit_cur ? cur_ch : rd_ch;
      end
    end
  end

  assign status.action   = act_q;
  assign status.out_free = !out_valid || m_tready;
  assign status.hop_cur  = hop[ri];
  assign status.i_last   = (ri == IW'(NUM_RADIOS - 1));
  assign status.j_last   = (rj == IW'(NUM_RADIOS - 1));

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_backup, out_main, out_ch, out_radio};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

/* test/radio_channel_hop_selector_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for radio_channel_hop_selector_top: directed and random
// start/tick/frame beats against an in-bench channel selection predictor.
// Depends on rchs_pkg and radio_channel_hop_selector_top.
module radio_channel_hop_selector_top_tb import rchs_pkg::*;;

  localparam int RADIOS        = 2;
  localparam int LIMIT         = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_SETTINGS  = 9;
  localparam int RAND_PER_SET  = 48;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] radio;
    logic       sync;
    logic [3:0] peer;
  } hop_event_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] radio;
    logic [3:0] chan;
    logic [2:0] main_r;
    logic [2:0] backup_r;
    logic       last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  radio_channel_hop_selector_top #(.NUM_RADIOS(RADIOS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- predictor state ----------------
  logic [3:0] chan_of   [RADIOS];
  logic [3:0] quiet_cnt [RADIOS];
  logic [2:0] main_sel_q   = SEL_NONE;
  logic [2:0] backup_sel_q = SEL_NONE;
  logic [3:0] free_time_q  = FREE_TIME_RESET;
  logic [4:0] chan_count_q = CHANNEL_COUNT_RESET;

  report_t    pending_reports [$];
  hop_event_t pending_events  [$];

  int errors = 0;
  int cycles = 0;
  int beats_in = 0, beats_out = 0, elections = 0, settings_run = 1;

  initial begin
    for (int i = 0; i < RADIOS; i++) begin
      chan_of[i]   = '0;
      quiet_cnt[i] = 4'd1;
    end
  end

  function automatic logic [4:0] usable_channels();
    return (chan_count_q > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : chan_count_q;
  endfunction

  function automatic logic [3:0] spread_chan(int i);
    return 4'((RADIOS - 1 - i) * (usable_channels() / RADIOS));
  endfunction

  function automatic logic [3:0] next_chan(logic [3:0] ch);
    logic [4:0] nx;
    nx = {1'b0, ch} + 5'd1;
    return (nx >= usable_channels()) ? 4'd0 : nx[3:0];
  endfunction

  function automatic void add_report(logic kind, logic [1:0] r, logic [3:0] ch, logic last);
    report_t t;
    t.kind     = kind;
    t.radio    = r;
    t.chan     = ch;
    t.main_r   = main_sel_q;
    t.backup_r = backup_sel_q;
    t.last     = last;
    pending_reports.push_back(t);
  endfunction

  // Works out the reports caused by one accepted beat and advances the state.
  function automatic void predict_retunes(logic [1:0] action, logic [1:0] radio,
                                          logic sync, logic [3:0] peer);
    logic hop [RADIOS];
    for (int i = 0; i < RADIOS; i++) hop[i] = 1'b0;
    case (action)
      ACT_START: begin
        main_sel_q   = SEL_NONE;
        backup_sel_q = SEL_NONE;
        for (int i = 0; i < RADIOS; i++) begin
          chan_of[i]   = spread_chan(i);
          quiet_cnt[i] = 4'd1;
        end
        for (int i = 0; i < RADIOS; i++)
          add_report(KIND_RETUNE, 2'(i), chan_of[i], i == RADIOS - 1);
      end
      ACT_FRAME: begin
        if (radio < RADIOS && !(sync && peer < NUM_PEERS)) quiet_cnt[radio] = 4'd0;
      end
      ACT_TICK: begin
        for (int i = 0; i < RADIOS; i++) begin
          if (main_sel_q == SEL_NONE && quiet_cnt[i] == free_time_q) begin
            main_sel_q = 3'(i);
            elections++;
            for (int j = 0; j < RADIOS; j++) begin
              if (j != i) begin
                backup_sel_q = 3'(j);
                chan_of[j]   = spread_chan(j);
                hop[j]       = 1'b1;
              end
            end
          end
        end
        for (int i = 0; i < RADIOS; i++)
          if (quiet_cnt[i] == 4'd0 && main_sel_q != 3'(i) && backup_sel_q != 3'(i))
            hop[i] = 1'b1;
        for (int i = 0; i < RADIOS; i++) begin
          if (hop[i]) begin
            chan_of[i] = next_chan(chan_of[i]);
            // skip channels held by other radios, scanned in index order
            for (int j = 0; j < RADIOS; j++)
              if (j != i && chan_of[i] == chan_of[j]) chan_of[i] = next_chan(chan_of[i]);
            add_report(KIND_RETUNE, 2'(i), chan_of[i], 1'b0);
          end
        end
        for (int i = 0; i < RADIOS; i++)
          if (quiet_cnt[i] < free_time_q) quiet_cnt[i] = quiet_cnt[i] + 4'd1;
        add_report(KIND_STATUS, 2'd0, 4'd0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [4:0] val);
    case (idx)
      CFG_FREE_TIME:     free_time_q  = val[3:0];
      CFG_CHANNEL_COUNT: chan_count_q = val;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------- driver ----------------
  logic       s_took = 1'b0, m_took = 1'b0;
  int         tx_gap = 0, tx_gap_max = 5;
  hop_event_t tx_ev;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        tx_ev = pending_events.pop_front();
        s_tdata  <= {2'b00, tx_ev.peer, tx_ev.radio};
        s_tuser  <= {tx_ev.sync, tx_ev.action};
        s_tvalid <= 1'b1;
        tx_gap = $urandom_range(0, tx_gap_max);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  int   rx_stall = 0, rx_gap_max = 5, hold_cnt = 0;
  logic press_on = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (press_on && hold_cnt < HOLD_CYCLES) begin
      // long hold-off so the block backs up and stalls its input
      hold_cnt <= hold_cnt + 1;
      m_tready <= 1'b0;
    end else begin
      if (m_took) rx_stall = $urandom_range(0, rx_gap_max);
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------- monitor ----------------
  report_t want;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      s_took <= !rst && s_tvalid && s_tready;
      m_took <= !rst && m_tvalid && m_tready;
      if (!rst) begin
        if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
        if (s_tvalid && s_tready) begin
          beats_in++;
          predict_retunes(s_tuser[1:0], s_tdata[1:0], s_tuser[2], s_tdata[5:2]);
        end
        if (m_tvalid && m_tready) begin
          beats_out++;
          if (pending_reports.size() == 0) begin
            $error("unexpected result beat: tdata %h tuser %b tlast %b",
                   m_tdata, m_tuser, m_tlast);
            errors++;
          end else begin
            want = pending_reports.pop_front();
            check_field("kind", want.kind, m_tuser[0]);
            check_field("tuned_radio", want.radio, m_tdata[1:0]);
            check_field("channel_index", want.chan, m_tdata[5:2]);
            check_field("main_radio", want.main_r, m_tdata[8:6]);
            check_field("backup_radio", want.backup_r, m_tdata[11:9]);
            check_field("last", want.last, m_tlast);
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic void push_event(logic [1:0] action, logic [1:0] radio,
                                     logic sync, logic [3:0] peer);
    hop_event_t e;
    e.action = action;
    e.radio  = radio;
    e.sync   = sync;
    e.peer   = peer;
    pending_events.push_back(e);
  endfunction

  function automatic void push_random(int frame_pct);
    hop_event_t e;
    int r;
    r = $urandom_range(0, 99);
    e.radio = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
    e.sync  = ($urandom_range(0, 9) < 7);
    e.peer  = 4'($urandom_range(0, 15));
    if (r < 4)                   e.action = ACT_START;
    else if (r < 7)              e.action = ACT_NONE;
    else if (r < 7 + frame_pct)  e.action = ACT_FRAME;
    else                         e.action = ACT_TICK;
    pending_events.push_back(e);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [3:0] ft, logic [4:0] cc);
    write_reg(CFG_FREE_TIME, {1'b0, ft});
    write_reg(CFG_CHANNEL_COUNT, cc);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for all beats out and all reports back, then let frame beats finish.
  task automatic drain();
    do @(posedge clk);
    while (pending_events.size() != 0 || s_tvalid || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [3:0] ft_list [NUM_SETTINGS];
    logic [4:0] cc_list [NUM_SETTINGS];
    int frame_pct;

    ft_list = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd2, 4'd4, 4'd15, 4'd5, 4'd1};
    cc_list = '{5'd0, 5'd31, 5'd5, 5'd1, 5'd2, 5'd17, 5'd16, 5'd16, 5'd3};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset-state tick, start, every frame case, election
    push_event(ACT_TICK, 2'd0, 1'b0, 4'd0);
    push_event(ACT_START, 2'd3, 1'b1, 4'd15);
    push_event(ACT_FRAME, 2'd0, 1'b0, 4'd0);
    push_event(ACT_FRAME, 2'd1, 1'b1, 4'd9);
    push_event(ACT_FRAME, 2'd1, 1'b1, 4'd10);
    push_event(ACT_FRAME, 2'd2, 1'b0, 4'd15);
    push_event(ACT_FRAME, 2'd3, 1'b1, 4'd5);
    push_event(ACT_NONE, 2'd3, 1'b1, 4'd15);
    push_event(ACT_FRAME, 2'd0, 1'b1, 4'd15);
    for (int k = 0; k < 7; k++) push_event(ACT_TICK, 2'(k), k[0], 4'(k));
    push_event(ACT_FRAME, 2'd1, 1'b0, 4'd3);
    push_event(ACT_TICK, 2'd0, 1'b0, 4'd0);
    push_event(ACT_FRAME, 2'd0, 1'b1, 4'd12);
    push_event(ACT_TICK, 2'd0, 1'b0, 4'd0);
    push_event(ACT_START, 2'd0, 1'b0, 4'd0);
    push_event(ACT_TICK, 2'd3, 1'b1, 4'd15);
    drain();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      set_config(ft_list[p], cc_list[p]);
      settings_run++;
      tx_gap_max = (p % 3 == 1) ? 0 : 5;
      rx_gap_max = (p % 4 == 2) ? 0 : 5;
      if (p == 2) press_on = 1'b1;
      frame_pct = $urandom_range(10, 45);
      push_event(ACT_START, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
      for (int k = 0; k < RAND_PER_SET; k++) push_random(frame_pct);
      drain();
    end

    if (pending_reports.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_reports.size());
      errors++;
    end
    $display("covered %0d input beats and %0d result beats under %0d register settings",
             beats_in, beats_out, settings_run);
    $display("main radio elected %0d times, %0d mismatches", elections, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
